[hw/rtl/srfd_pkg.sv]
// Shared constants, codes and types of the sensor response frame decoder.
`default_nettype none

package srfd_pkg;

   localparam logic [7:0] MARK_BYTE = 8'hF5;

   // Bytes 1 to 6 of a frame are held; byte 7 arrives with the final transfer.
   localparam int FRAME_BODY = 6;
   localparam int POS_WIDTH = 3;
   localparam logic [POS_WIDTH-1:0] POS_HUNT = 3'd0;
   localparam logic [POS_WIDTH-1:0] POS_LAST = 3'd7;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_USER_ID = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_USER_ID = 1'd1;
   localparam logic [15:0] MIN_USER_ID_RESET = 16'd1;
   localparam logic [15:0] MAX_USER_ID_RESET = 16'd150;

   localparam logic [7:0] CMD_ENROLL_1 = 8'h01;
   localparam logic [7:0] CMD_ENROLL_2 = 8'h02;
   localparam logic [7:0] CMD_ENROLL_3 = 8'h03;
   localparam logic [7:0] CMD_DELETE_USER = 8'h04;
   localparam logic [7:0] CMD_DELETE_ALL = 8'h05;
   localparam logic [7:0] CMD_SET_LEVEL = 8'h2E;
   localparam logic [7:0] CMD_READ_USER = 8'h0B;
   localparam logic [7:0] CMD_QUERY_COUNT = 8'h09;
   localparam logic [7:0] CMD_SEARCH = 8'h0C;

   localparam logic [7:0] ACK_OK = 8'h00;
   localparam logic [7:0] ACK_UNKNOWN_CMD = 8'h01;
   localparam logic [7:0] ACK_NOUSER = 8'h05;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_BAD      = 2'd1,
      KIND_STALE    = 2'd2
   } kind_type;

   // body[k-1] holds frame byte k.
   typedef struct packed {
      logic [7:0]                 cmd;
      logic [FRAME_BODY-1:0][7:0] body;
      logic [7:0]                 tail;
   } frame_type;

   typedef struct packed {
      kind_type    kind;
      logic        success;
      logic [7:0]  ack;
      logic [15:0] user_id;
      logic [7:0]  stored_count;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/srfd_channels.sv]
// Handshake channel interfaces for received bytes, decoded results and register writes.
`default_nettype none

interface srfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [7:0] awaited_cmd;

   modport source (output valid, output rx_byte, output awaited_cmd, input ready);
   modport sink (input valid, input rx_byte, input awaited_cmd, output ready);
endinterface

interface srfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_kind;
   logic        success;
   logic [7:0]  ack_code;
   logic [15:0] user_id;
   logic [7:0]  stored_count;

   modport source (output valid, output frame_kind, output success, output ack_code,
                   output user_id, output stored_count, input ready);
   modport sink (input valid, input frame_kind, input success, input ack_code,
                 input user_id, input stored_count, output ready);
endinterface

interface srfd_csr_if import srfd_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/srfd_collect.sv]
// Start byte hunt and frame assembly into a registered frame.
`default_nettype none

module srfd_collect import srfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   srfd_req_if.sink   req_bus,
   input  logic       frame_take,
   output logic       frame_valid,
   output frame_type  frame
);

   logic [POS_WIDTH-1:0]       pos_ff, pos_in;
   logic [FRAME_BODY-1:0][7:0] body_ff, body_in;
   logic                       frame_valid_ff, frame_valid_in;
   frame_type                  frame_ff, frame_in;
   logic                       accept;
   logic                       last;
   logic [POS_WIDTH-1:0]       slot;

   assign req_bus.ready = !frame_valid_ff || frame_take;
   assign accept = req_bus.valid && req_bus.ready;
   assign last = accept && (pos_ff == POS_LAST);
   assign slot = pos_ff - POS_WIDTH'(1);

   always_comb begin
      pos_in = pos_ff;
      body_in = body_ff;
      if (accept) begin
         if (pos_ff == POS_HUNT) begin
            if (req_bus.rx_byte == MARK_BYTE) begin
               pos_in = POS_HUNT + POS_WIDTH'(1);
            end
         end else if (pos_ff != POS_LAST) begin
            body_in[slot] = req_bus.rx_byte;
            pos_in = pos_ff + POS_WIDTH'(1);
         end else begin
            pos_in = POS_HUNT;
         end
      end
   end

   always_comb begin
      frame_in = frame_ff;
      if (last) begin
         frame_in.cmd = req_bus.awaited_cmd;
         frame_in.body = body_ff;
         frame_in.tail = req_bus.rx_byte;
      end
      frame_valid_in = last || (frame_valid_ff && !frame_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
         frame_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      body_ff <= body_in;
      frame_ff <= frame_in;
   end

   assign frame_valid = frame_valid_ff;
   assign frame = frame_ff;

   // Inside a frame every transfer before the last byte moves one position forward.
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      accept && pos_ff != POS_HUNT && pos_ff != POS_LAST
      |=> pos_ff == $past(pos_ff) + POS_WIDTH'(1))
      else $error("frame position did not advance");

   a_hunt_hold: assert property (@(posedge clock) disable iff (reset)
      pos_ff == POS_HUNT && !(accept && req_bus.rx_byte == MARK_BYTE)
      |=> pos_ff == POS_HUNT)
      else $error("left hunt without a start byte");

   // A completed frame waits unchanged until the decoder takes it.
   a_frame_hold: assert property (@(posedge clock) disable iff (reset)
      frame_valid_ff && !frame_take |=> frame_valid_ff && frame_ff == $past(frame_ff))
      else $error("pending frame lost or changed");

endmodule

`default_nettype wire

[hw/rtl/srfd_decode.sv]
// Frame check, command decode, user id and count state, and the result register.
`default_nettype none

module srfd_decode import srfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] min_user_id,
   input  logic [15:0] max_user_id,
   input  logic        frame_valid,
   input  frame_type   frame,
   output logic        frame_take,
   srfd_rsp_if.source  rsp_bus
);

   logic [15:0] user_ff, user_in;
   logic [7:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff, result_in;

   logic        load;
   logic [7:0]  sum;
   logic [15:0] pair;
   logic [7:0]  level;
   logic [7:0]  uid8;
   logic [15:0] new_user;
   logic [7:0]  new_count;
   logic [7:0]  ack;
   kind_type    kind;

   assign frame_take = !rsp_valid_ff || rsp_bus.ready;
   assign load = frame_valid && frame_take;

   assign sum = frame.body[0] ^ frame.body[1] ^ frame.body[2] ^ frame.body[3] ^ frame.body[4];
   assign pair = {frame.body[1], frame.body[2]};
   assign level = frame.body[3];
   // Search reports the slot in byte 3, or in byte 2 when only that one is in range.
   assign uid8 = ({8'h00, frame.body[2]} < min_user_id &&
                  {8'h00, frame.body[1]} >= min_user_id) ? frame.body[1] : frame.body[2];

   always_comb begin
      new_user = user_ff;
      new_count = count_ff;
      ack = ACK_OK;
      if (frame.tail != MARK_BYTE || frame.body[5] != sum) begin
         kind = KIND_BAD;
      end else if (frame.body[0] != frame.cmd) begin
         kind = KIND_STALE;
      end else begin
         kind = KIND_ACCEPTED;
         case (frame.cmd)
            CMD_ENROLL_1, CMD_ENROLL_2, CMD_ENROLL_3,
            CMD_DELETE_USER, CMD_DELETE_ALL, CMD_SET_LEVEL: begin
               ack = level;
            end
            CMD_READ_USER: begin
               if (level == ACK_OK) begin
                  new_user = pair;
               end
               ack = level;
            end
            CMD_QUERY_COUNT: begin
               if (level == ACK_OK || (pair != 16'd0 && pair <= max_user_id)) begin
                  new_count = (pair[15:8] != 8'h00) ? COUNT_MAX : pair[7:0];
                  new_user = {8'h00, new_count};
                  ack = ACK_OK;
               end else begin
                  ack = level;
               end
            end
            CMD_SEARCH: begin
               if (level >= 8'd1 && level <= 8'd3 && {8'h00, uid8} >= min_user_id) begin
                  new_user = {8'h00, uid8};
                  ack = ACK_OK;
               end else if (level == ACK_OK && pair >= min_user_id) begin
                  new_user = pair;
                  ack = ACK_OK;
               end else begin
                  ack = ACK_NOUSER;
               end
            end
            default: begin
               ack = ACK_UNKNOWN_CMD;
            end
         endcase
      end
   end

   always_comb begin
      user_in = load ? new_user : user_ff;
      count_in = load ? new_count : count_ff;
      result_in = result_ff;
      if (load) begin
         result_in.kind = kind;
         result_in.success = (kind == KIND_ACCEPTED) && (ack == ACK_OK);
         result_in.ack = ack;
         result_in.user_id = new_user;
         result_in.stored_count = new_count;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_ff <= 16'd0;
         count_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         user_ff <= user_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.frame_kind = result_ff.kind;
   assign rsp_bus.success = result_ff.success;
   assign rsp_bus.ack_code = result_ff.ack;
   assign rsp_bus.user_id = result_ff.user_id;
   assign rsp_bus.stored_count = result_ff.stored_count;

   // A bad or stale frame never carries an ack or a success.
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.kind != KIND_ACCEPTED
      |-> result_ff.ack == ACK_OK && !result_ff.success)
      else $error("rejected frame reports an ack");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(user_ff) && $stable(count_ff))
      else $error("state changed without a frame");

   // The waiting result always reflects the current state.
   a_result_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> result_ff.user_id == user_ff && result_ff.stored_count == count_ff)
      else $error("result out of step with state");

endmodule

`default_nettype wire

[hw/rtl/sensor_response_frame_decoder_unit.sv]
// Top level of the sensor response frame decoder: configuration registers and datapath.
//
// Usage: received link bytes enter on req_bus, one per transfer, each with the
// command code whose response is awaited (the code given with the last byte of
// a frame is the one that counts). Bytes are dropped until a start byte 0xF5
// arrives; the next seven bytes complete a frame. Each completed frame yields
// one transfer on rsp_bus: accepted, bad (end byte or checksum) or stale echo,
// with the decoded ack, success flag, last user id and stored template count.
// csr_bus writes min_user_id (index 0) and max_user_id (index 1); it is always
// ready and should be written only while no frame is in flight.
// Throughput is one byte per cycle while req_bus.ready is high. The last byte
// of a frame is registered in the frame register, and the decode stage reads
// it there to feed the result register. If rsp_bus stalls, one result waits
// in the result register and the next completed frame waits in the frame
// register; req_bus.ready is low whenever that frame register is occupied and
// cannot move on, whatever the byte position.
// Reset clears the byte position to hunting, the user id and count to zero,
// and the registers to 1 and 150; no result is pending after reset.
`default_nettype none

module sensor_response_frame_decoder_unit import srfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   srfd_req_if.sink   req_bus,
   srfd_rsp_if.source rsp_bus,
   srfd_csr_if.sink   csr_bus
);

   logic [15:0] min_user_id_ff, min_user_id_in;
   logic [15:0] max_user_id_ff, max_user_id_in;
   logic        frame_take;
   logic        frame_valid;
   frame_type   frame;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      min_user_id_in = min_user_id_ff;
      max_user_id_in = max_user_id_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_MIN_USER_ID: min_user_id_in = csr_bus.data;
            CSR_MAX_USER_ID: max_user_id_in = csr_bus.data;
            default: begin
               min_user_id_in = min_user_id_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_user_id_ff <= MIN_USER_ID_RESET;
         max_user_id_ff <= MAX_USER_ID_RESET;
      end else begin
         min_user_id_ff <= min_user_id_in;
         max_user_id_ff <= max_user_id_in;
      end
   end

   srfd_collect u_collect (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .frame_take  (frame_take),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   srfd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .min_user_id (min_user_id_ff),
      .max_user_id (max_user_id_ff),
      .frame_valid (frame_valid),
      .frame       (frame),
      .frame_take  (frame_take),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

[sim/srfd_frame_checker.sv]
`timescale 1ns / 100ps
// Frame result predictor and scoreboard for the sensor response frame decoder.
module srfd_frame_checker import srfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   srfd_req_if         req_bus,
   srfd_rsp_if         rsp_bus,
   srfd_csr_if         csr_bus,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);

   localparam logic [7:0] SEARCH_LEVEL_LO = 8'd1;
   localparam logic [7:0] SEARCH_LEVEL_HI = 8'd3;

   logic [15:0] min_uid;
   logic [15:0] max_uid;
   logic [2:0]  position;
   logic [7:0]  body [1:7];
   logic [15:0] last_uid;
   logic [7:0]  stored;
   int unsigned fail_tally;
   result_type  expected_results [$];

   task automatic note_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
      if (want !== got) begin
         fail_tally++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   task automatic absorb_byte(input logic [7:0] rx, input logic [7:0] cmd);
      logic [7:0]  csum;
      logic [7:0]  level;
      logic [7:0]  ack;
      logic [15:0] pair;
      logic [15:0] uid;
      kind_type    kind;
      result_type  res;
      if (position == POS_HUNT) begin
         if (rx == MARK_BYTE) position = 3'd1;
      end else if (position != POS_LAST) begin
         body[position] = rx;
         position = position + 3'd1;
      end else begin
         body[7] = rx;
         position = POS_HUNT;
         csum = body[1] ^ body[2] ^ body[3] ^ body[4] ^ body[5];
         pair = {body[2], body[3]};
         level = body[4];
         ack = ACK_OK;
         if (body[7] != MARK_BYTE || body[6] != csum) begin
            kind = KIND_BAD;
         end else if (body[1] != cmd) begin
            kind = KIND_STALE;
         end else begin
            kind = KIND_ACCEPTED;
            ack = level;
            case (cmd)
               CMD_ENROLL_1, CMD_ENROLL_2, CMD_ENROLL_3,
               CMD_DELETE_USER, CMD_DELETE_ALL, CMD_SET_LEVEL: begin
               end
               CMD_READ_USER: begin
                  if (level == ACK_OK) last_uid = pair;
               end
               CMD_QUERY_COUNT: begin
                  if (level == ACK_OK || (pair != 16'd0 && pair <= max_uid)) begin
                     stored = (pair > {8'd0, COUNT_MAX}) ? COUNT_MAX : pair[7:0];
                     last_uid = {8'd0, stored};
                     ack = ACK_OK;
                  end
               end
               CMD_SEARCH: begin
                  ack = ACK_NOUSER;
                  if (level >= SEARCH_LEVEL_LO && level <= SEARCH_LEVEL_HI) begin
                     // The low id byte wins unless only the high one is a valid slot.
                     uid = {8'd0, body[3]};
                     if (uid < min_uid && {8'd0, body[2]} >= min_uid) uid = {8'd0, body[2]};
                     if (uid >= min_uid) begin
                        last_uid = uid;
                        ack = ACK_OK;
                     end
                  end else if (level == ACK_OK && pair >= min_uid) begin
                     last_uid = pair;
                     ack = ACK_OK;
                  end
               end
               default: ack = ACK_UNKNOWN_CMD;
            endcase
         end
         res.kind = kind;
         res.success = (kind == KIND_ACCEPTED && ack == ACK_OK);
         res.ack = ack;
         res.user_id = last_uid;
         res.stored_count = stored;
         expected_results.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         min_uid = MIN_USER_ID_RESET;
         max_uid = MAX_USER_ID_RESET;
         position = POS_HUNT;
         last_uid = 16'd0;
         stored = 8'd0;
         fail_tally = 0;
         expected_results.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_MIN_USER_ID: min_uid = csr_bus.data;
               CSR_MAX_USER_ID: max_uid = csr_bus.data;
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) absorb_byte(req_bus.rx_byte, req_bus.awaited_cmd);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               fail_tally++;
               $display("%0t: result transfer with no frame pending, expected none, %s %0d ack %0h",
                        $time, "got kind", rsp_bus.frame_kind, rsp_bus.ack_code);
            end else begin
               want = expected_results.pop_front();
               note_field("frame_kind", 16'(want.kind), 16'(rsp_bus.frame_kind));
               note_field("success", 16'(want.success), 16'(rsp_bus.success));
               note_field("ack_code", 16'(want.ack), 16'(rsp_bus.ack_code));
               note_field("user_id", want.user_id, rsp_bus.user_id);
               note_field("stored_count", 16'(want.stored_count), 16'(rsp_bus.stored_count));
            end
         end
      end
      mismatch_count <= fail_tally;
      pending_count <= expected_results.size();
   end

endmodule

[sim/sensor_response_frame_decoder_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the sensor response frame decoder: frame stimulus, register writes, verdict.
module sensor_response_frame_decoder_unit_tb;
   import srfd_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 250000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_GOAL = 1350;
   localparam int PHASES = 7;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int          burst_left = 0;
   int          sink_mode = 0;
   int          sink_hold = 0;
   int          items_sent = 0;
   logic [15:0] cur_min;
   logic [15:0] cur_max;

   srfd_req_if req_bus ();
   srfd_rsp_if rsp_bus ();
   srfd_csr_if csr_bus ();

   sensor_response_frame_decoder_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   srfd_frame_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("sensor_response_frame_decoder_unit test failed");
         $finish;
      end
   end

   // The result side switches between free flow, light and heavy stalling.
   always @(posedge clock) begin
      if (sink_hold == 0) begin
         sink_mode = $urandom_range(0, 3);
         sink_hold = $urandom_range(16, 160);
      end else begin
         sink_hold = sink_hold - 1;
      end
      case (sink_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] value, input logic [7:0] awaited);
      int gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_bus.valid       <= 1'b1;
      req_bus.rx_byte     <= value;
      req_bus.awaited_cmd <= awaited;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // Only the awaited code given with the final byte matters; the others are random.
   task automatic send_frame(input logic [7:0] cmd, input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] level, input logic [7:0] extra,
                             input logic [7:0] csum_flip, input logic [7:0] tail_flip,
                             input logic [7:0] echo_flip);
      logic [7:0] csum;
      csum = cmd ^ hi ^ lo ^ level ^ extra;
      push_byte(MARK_BYTE, rand_byte());
      push_byte(cmd, rand_byte());
      push_byte(hi, rand_byte());
      push_byte(lo, rand_byte());
      push_byte(level, rand_byte());
      push_byte(extra, rand_byte());
      push_byte(csum ^ csum_flip, rand_byte());
      push_byte(MARK_BYTE ^ tail_flip, cmd ^ echo_flip);
      items_sent += 8;
   endtask

   function automatic logic [7:0] known_cmd(input int pick);
      case (pick)
         0: return CMD_ENROLL_1;
         1: return CMD_ENROLL_2;
         2: return CMD_ENROLL_3;
         3: return CMD_DELETE_USER;
         4: return CMD_DELETE_ALL;
         5: return CMD_SET_LEVEL;
         6, 9: return CMD_READ_USER;
         7, 10: return CMD_QUERY_COUNT;
         default: return CMD_SEARCH;
      endcase
   endfunction

   // Id bytes lean toward the edges and toward the current slot limits.
   function automatic logic [7:0] id_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'(cur_min[7:0] + $urandom_range(0, 2) - 1);
         3: return 8'(cur_max[7:0] + $urandom_range(0, 2) - 1);
         default: return rand_byte();
      endcase
   endfunction

   function automatic logic [7:0] corruption(input int percent);
      return ($urandom_range(0, 99) < percent) ? 8'($urandom_range(1, 255)) : 8'h00;
   endfunction

   task automatic send_random_frame();
      logic [7:0]  cmd;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [7:0]  level;
      logic [7:0]  junk;
      logic [15:0] pair;
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            junk = rand_byte();
            if (junk == MARK_BYTE) junk = ~junk;
            push_byte(junk, rand_byte());
         end
      end
      cmd = ($urandom_range(0, 99) < 12) ? rand_byte() : known_cmd(int'($urandom_range(0, 11)));
      hi = id_byte();
      lo = id_byte();
      if ($urandom_range(0, 3) == 0) begin
         pair = 16'($urandom_range(0, int'(cur_max) + 2));
         {hi, lo} = pair;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: level = ACK_OK;
         3, 4, 5: level = 8'($urandom_range(1, 3));
         6: level = 8'($urandom_range(4, 5));
         default: level = rand_byte();
      endcase
      send_frame(cmd, hi, lo, level, rand_byte(),
                 corruption(8), corruption(6), corruption(8));
   endtask

   task automatic write_limits(input logic [15:0] lowest, input logic [15:0] highest);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_MIN_USER_ID;
      csr_bus.data  <= lowest;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.index <= CSR_MAX_USER_ID;
      csr_bus.data  <= highest;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Waits until every predicted result has been transferred, then lets the pipeline empty.
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int p;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = 8'h00;
      req_bus.awaited_cmd = 8'h00;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MIN_USER_ID;
      csr_bus.data = 16'h0000;
      cur_min = MIN_USER_ID_RESET;
      cur_max = MAX_USER_ID_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray bytes while hunting, a saturating count, a search that
      // falls back to the high id byte, and an unknown command.
      push_byte(8'h00, 8'h00);
      push_byte(8'hFF, 8'hFF);
      send_frame(CMD_QUERY_COUNT, 8'hFF, 8'hFF, ACK_OK, 8'hFF, 8'h00, 8'h00, 8'h00);
      send_frame(CMD_SEARCH, 8'h07, 8'h00, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
      send_frame(8'h77, 8'h12, 8'h34, ACK_OK, 8'h56, 8'h00, 8'h00, 8'h00);

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: begin cur_min = 16'h0000; cur_max = 16'hFFFF; end
               2: begin cur_min = 16'hFFFF; cur_max = 16'h0000; end
               3: begin
                  cur_min = 16'($urandom_range(1, 20));
                  cur_max = 16'($urandom_range(0, 300));
               end
               4: begin
                  cur_min = 16'($urandom_range(100, 255));
                  cur_max = 16'($urandom_range(256, 1000));
               end
               5: begin
                  cur_min = 16'($urandom_range(0, 65535));
                  cur_max = 16'($urandom_range(0, 65535));
               end
               default: begin cur_min = MIN_USER_ID_RESET; cur_max = MAX_USER_ID_RESET; end
            endcase
            write_limits(cur_min, cur_max);
         end
         while (items_sent < (p + 1) * ITEM_GOAL / PHASES) send_random_frame();
      end

      settle();
      if (mismatch_count == 0)
         $display("sensor_response_frame_decoder_unit test passed");
      else
         $display("sensor_response_frame_decoder_unit test failed");
      $finish;
   end

endmodule
